>>> hw/rtl/lse_pkg.sv
// Shared types, codes and helpers for the LACP port selection engine.
package lse_pkg;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_KEY    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MODE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PORTS_IN_USE = 8'd3;

    localparam logic [15:0] LOCAL_KEY_RESET    = 16'd1;
    localparam logic        ACTIVE_MODE_RESET  = 1'b1;
    localparam logic [63:0] TIMEOUT_RESET      = 64'd1000000000;
    localparam logic [3:0]  PORTS_IN_USE_RESET = 4'd8;

    // Bit positions in the sender's state byte
    localparam int AGG_BIT  = 2;
    localparam int COLL_BIT = 4;
    localparam int DIST_BIT = 5;

    localparam logic [1:0] ST_DETACHED     = 2'd0;
    localparam logic [1:0] ST_ATTACHED     = 2'd1;
    localparam logic [1:0] ST_COLLECTING   = 2'd2;
    localparam logic [1:0] ST_DISTRIBUTING = 2'd3;

    localparam logic KIND_LACPDU = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam logic CAUSE_NEGOTIATION = 1'b0;
    localparam logic CAUSE_TIMEOUT     = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [2:0]  port;
        logic        parsed;
        logic [15:0] peer_key;
        logic [7:0]  sender_state;
        logic [15:0] partner_priority;
        logic [63:0] now;
    } req_t;

    typedef struct packed {
        logic [2:0]  out_port;
        logic        cause;
        logic [1:0]  port_state;
        logic        selected;
        logic [15:0] stored_peer_key;
        logic [15:0] stored_partner_priority;
        logic [7:0]  member_mask;
        logic [3:0]  member_total;
        logic        last;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic ev_load;
        logic scan_step;
        logic emit_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_kind;
        logic ev_hit;
        logic scan_last;
        logic exp_any;
        logic emit_last;
        logic out_free;
    } sts_t;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + {3'd0, v[i]};
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/lse_ctrl.sv
// Sequencing controller of the LACP port selection engine.
module lse_ctrl
    import lse_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVENT = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (sts.req_kind == KIND_TICK) ? S_SCAN : S_EVENT;
                end
            end
            S_EVENT:
            begin
                if (!sts.ev_hit)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.ev_load = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!sts.exp_any)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/lse_dp.sv
// Datapath of the LACP port selection engine: port tables, registers, result stage.
module lse_dp
    import lse_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  req_t                  req_data,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp_data,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration
    logic [15:0] local_key_reg;
    logic        active_mode_reg;
    logic [63:0] timeout_reg;
    logic [3:0]  ports_in_use_reg;

    // Port tables
    logic [1:0]  st_reg    [DEPTH];
    logic        sel_reg   [DEPTH];
    logic [15:0] key_reg   [DEPTH];
    logic [15:0] prio_reg  [DEPTH];
    logic [63:0] stamp_reg [DEPTH];

    // Request, scan and result state
    req_t             req_reg;
    logic [IDX_W-1:0] scan_idx_reg;
    logic [DEPTH-1:0] exp_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic [3:0]       n4;
    logic [IDX_W-1:0] ev_idx;
    logic             keys_agree;
    logic [1:0]       ev_st;
    logic             ev_sel;
    logic [7:0]       mask_cur;
    logic [7:0]       mask_ev;
    logic [7:0]       mask_em;
    logic             scan_in_range;
    logic [63:0]      scan_stamp;
    logic [64:0]      age;
    logic             scan_expired;
    logic [IDX_W-1:0] e_idx;
    logic             e_found;
    logic [DEPTH-1:0] exp_rest;
    logic             out_free;

    assign n4     = (ports_in_use_reg > 4'(DEPTH)) ? 4'(DEPTH) : ports_in_use_reg;
    assign ev_idx = req_reg.port[IDX_W-1:0];

    // Negotiate the new port state from the received LACPDU
    assign keys_agree = (req_reg.peer_key != 16'd0)
                     && (req_reg.peer_key == local_key_reg)
                     && req_reg.sender_state[AGG_BIT];

    always_comb
    begin
        ev_sel = 1'b0;
        ev_st  = ST_DETACHED;
        if (keys_agree)
        begin
            ev_sel = 1'b1;
            ev_st  = ST_ATTACHED;
            if (req_reg.sender_state[COLL_BIT])
            begin
                ev_st = ST_COLLECTING;
                if (req_reg.sender_state[DIST_BIT] || active_mode_reg)
                begin
                    ev_st = ST_DISTRIBUTING;
                end
            end
        end
    end

    always_comb
    begin
        mask_cur = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            mask_cur[i] = (4'(i) < n4) && sel_reg[i] && (st_reg[i] == ST_DISTRIBUTING);
        end
    end

    always_comb
    begin
        mask_ev = mask_cur;
        mask_ev[req_reg.port] = ev_sel && (ev_st == ST_DISTRIBUTING);
    end

    // Age check of the scanned port
    assign scan_in_range = 4'(scan_idx_reg) < n4;
    assign scan_stamp    = scan_in_range ? stamp_reg[scan_idx_reg] : 64'd0;
    assign age           = {1'b0, req_reg.now} - {1'b0, scan_stamp};
    assign scan_expired  = scan_in_range && (scan_stamp != 64'd0) && !age[64]
                        && (age[63:0] >= timeout_reg);

    // Lowest expired port goes out first
    always_comb
    begin
        e_idx   = '0;
        e_found = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!e_found && exp_reg[i])
            begin
                e_idx   = IDX_W'(i);
                e_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        exp_rest        = exp_reg;
        exp_rest[e_idx] = 1'b0;
        mask_em         = mask_cur;
        mask_em[3'(e_idx)] = 1'b0;
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;

    assign sts.req_kind  = req_data.kind;
    assign sts.ev_hit    = req_reg.parsed && ({1'b0, req_reg.port} < n4);
    assign sts.scan_last = (4'(scan_idx_reg) + 4'd1) >= n4;
    assign sts.exp_any   = e_found;
    assign sts.emit_last = (exp_rest == '0);
    assign sts.out_free  = out_free;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_key_reg    <= LOCAL_KEY_RESET;
            active_mode_reg  <= ACTIVE_MODE_RESET;
            timeout_reg      <= TIMEOUT_RESET;
            ports_in_use_reg <= PORTS_IN_USE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LOCAL_KEY:    local_key_reg    <= cfg_data[15:0];
                REG_ACTIVE_MODE:  active_mode_reg  <= cfg_data[0];
                REG_TIMEOUT:      timeout_reg      <= cfg_data;
                REG_PORTS_IN_USE: ports_in_use_reg <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    // Port tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                st_reg[i]    <= ST_DETACHED;
                sel_reg[i]   <= 1'b0;
                key_reg[i]   <= 16'd0;
                prio_reg[i]  <= 16'd0;
                stamp_reg[i] <= 64'd0;
            end
        end
        else if (cmd.ev_load)
        begin
            st_reg[ev_idx]    <= ev_st;
            sel_reg[ev_idx]   <= ev_sel;
            key_reg[ev_idx]   <= req_reg.peer_key;
            prio_reg[ev_idx]  <= req_reg.partner_priority;
            stamp_reg[ev_idx] <= req_reg.now;
        end
        else if (cmd.emit_load)
        begin
            st_reg[e_idx]    <= ST_DETACHED;
            sel_reg[e_idx]   <= 1'b0;
            key_reg[e_idx]   <= 16'd0;
            stamp_reg[e_idx] <= 64'd0;
        end
    end

    // Request capture, scan counter and expired set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            exp_reg      <= '0;
        end
        else if (cmd.capture)
        begin
            scan_idx_reg <= '0;
            exp_reg      <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            if (scan_expired)
            begin
                exp_reg[scan_idx_reg] <= 1'b1;
            end
        end
        else if (cmd.emit_load)
        begin
            exp_reg <= exp_rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_data;
        end
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.ev_load || cmd.emit_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ev_load)
        begin
            rsp_reg.out_port                <= req_reg.port;
            rsp_reg.cause                   <= CAUSE_NEGOTIATION;
            rsp_reg.port_state              <= ev_st;
            rsp_reg.selected                <= ev_sel;
            rsp_reg.stored_peer_key         <= req_reg.peer_key;
            rsp_reg.stored_partner_priority <= req_reg.partner_priority;
            rsp_reg.member_mask             <= mask_ev;
            rsp_reg.member_total            <= popcount8(mask_ev);
            rsp_reg.last                    <= 1'b1;
        end
        else if (cmd.emit_load)
        begin
            rsp_reg.out_port                <= 3'(e_idx);
            rsp_reg.cause                   <= CAUSE_TIMEOUT;
            rsp_reg.port_state              <= ST_DETACHED;
            rsp_reg.selected                <= 1'b0;
            rsp_reg.stored_peer_key         <= 16'd0;
            rsp_reg.stored_partner_priority <= prio_reg[e_idx];
            rsp_reg.member_mask             <= mask_em;
            rsp_reg.member_total            <= popcount8(mask_em);
            rsp_reg.last                    <= sts.emit_last;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ev_load || cmd.emit_load) |-> out_free)
        else $error("result loaded over an unaccepted result");

    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ev_load && cmd.emit_load))
        else $error("event and timeout result loaded together");

    a_emit_only_expired: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> exp_reg[e_idx])
        else $error("timeout reported for a port that did not expire");

    a_emit_clears_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |=> (stamp_reg[$past(e_idx)] == 64'd0) && !exp_reg[$past(e_idx)])
        else $error("timed-out port not cleared");

endmodule

>>> hw/rtl/lacp_port_selection_engine.sv
// Top level of the LACP port selection engine: controller plus datapath.
//
// Channels: req_* carries one request (an LACPDU event or a timer tick), taken
// when req_valid is high and req_stall is low. rsp_* carries results, taken
// when rsp_valid is high and rsp_stall is low. cfg_* writes registers
// (0 local key, 1 active_mode, 2 timeout, 3 ports_in_use); cfg_ready is always
// high, writes are meant for idle time only.
// Sequencing: one request at a time. An LACPDU gives at most one result,
// loaded from the EVENT state once the result register is free. A tick
// age-checks the n member ports in the SCAN state, one port per cycle
// through a single 64-bit subtract and compare, then the EMIT state gives
// one result per timed-out port as the result register frees, and none
// when no port timed out.
// The result register frees the request side: the next request is accepted
// while a finished result still waits on rsp_stall. A stalled result holds,
// and a pending LACPDU result or the emit sequence waits until it drains.
// Reset: asynchronous, clears all port tables (detached, unselected, keys,
// priorities and stamps zero) and loads the register defaults at once.
module lacp_port_selection_engine
    import lse_pkg::*;
#(
    parameter int NUM_PORTS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Port numbers are three bits wide, so at most eight table entries exist
    localparam int DEPTH = (NUM_PORTS < 8) ? NUM_PORTS : 8;

    cmd_t cmd;
    sts_t sts;

    // Registers accept a write on any cycle
    assign cfg_ready = 1'b1;

    lse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    lse_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

>>> tb/sv/lse_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Port table predictor and result scoreboard for the LACP port selection engine.
package lse_scoreboard_pkg;
    import lse_pkg::*;

    localparam int TABLE_PORTS = 8;

    class lse_scoreboard;
        // Mirror of the block's per-port table
        logic [1:0]  state_tab [TABLE_PORTS];
        logic        sel_tab   [TABLE_PORTS];
        logic [15:0] key_tab   [TABLE_PORTS];
        logic [15:0] prio_tab  [TABLE_PORTS];
        logic [63:0] stamp_tab [TABLE_PORTS];

        // Mirror of the register file
        logic [15:0] local_key;
        logic        active_mode;
        logic [63:0] age_limit;
        logic [3:0]  ports_in_use;

        rsp_t pending_q[$];
        int   errors;
        int   checked;

        function new();
            for (int i = 0; i < TABLE_PORTS; i++)
            begin
                state_tab[i] = ST_DETACHED;
                sel_tab[i]   = 1'b0;
                key_tab[i]   = '0;
                prio_tab[i]  = '0;
                stamp_tab[i] = '0;
            end
            local_key    = LOCAL_KEY_RESET;
            active_mode  = ACTIVE_MODE_RESET;
            age_limit    = TIMEOUT_RESET;
            ports_in_use = PORTS_IN_USE_RESET;
            errors       = 0;
            checked      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LOCAL_KEY:    local_key    = data[15:0];
                REG_ACTIVE_MODE:  active_mode  = data[0];
                REG_TIMEOUT:      age_limit    = data;
                REG_PORTS_IN_USE: ports_in_use = data[3:0];
                default:          ;
            endcase
        endfunction

        function int member_ports();
            return (ports_in_use > TABLE_PORTS) ? TABLE_PORTS : int'(ports_in_use);
        endfunction

        function logic [7:0] distributing_mask();
            logic [7:0] mask;
            mask = '0;
            for (int i = 0; i < member_ports(); i++)
            begin
                if (sel_tab[i] && state_tab[i] == ST_DISTRIBUTING)
                    mask[i] = 1'b1;
            end
            return mask;
        endfunction

        function rsp_t port_report(int p, logic cause);
            rsp_t o;
            logic [7:0] mask;
            mask = distributing_mask();
            o = '0;
            o.out_port                = p[2:0];
            o.cause                   = cause;
            o.port_state              = state_tab[p];
            o.selected                = sel_tab[p];
            o.stored_peer_key         = key_tab[p];
            o.stored_partner_priority = prio_tab[p];
            o.member_mask             = mask;
            o.member_total            = 4'($countones(mask));
            o.last                    = 1'b0;
            return o;
        endfunction

        // Update the table for one accepted request and queue the results it causes.
        function int note_request(req_t r);
            int n;
            int produced;
            int p;
            n = member_ports();
            produced = 0;
            if (r.kind == KIND_LACPDU)
            begin
                if (r.parsed && int'(r.port) < n)
                begin
                    p = int'(r.port);
                    stamp_tab[p] = r.now;
                    key_tab[p]   = r.peer_key;
                    prio_tab[p]  = r.partner_priority;
                    if (r.peer_key == '0 || r.peer_key != local_key
                        || !r.sender_state[AGG_BIT])
                    begin
                        state_tab[p] = ST_DETACHED;
                        sel_tab[p]   = 1'b0;
                    end
                    else
                    begin
                        sel_tab[p]   = 1'b1;
                        state_tab[p] = ST_ATTACHED;
                        if (r.sender_state[COLL_BIT])
                            state_tab[p] = ST_COLLECTING;
                        if (r.sender_state[COLL_BIT]
                            && (r.sender_state[DIST_BIT] || active_mode))
                            state_tab[p] = ST_DISTRIBUTING;
                    end
                    pending_q.push_back(port_report(p, CAUSE_NEGOTIATION));
                    produced = 1;
                end
            end
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (stamp_tab[i] == '0 || r.now < stamp_tab[i])
                        continue;
                    if (r.now - stamp_tab[i] < age_limit)
                        continue;
                    state_tab[i] = ST_DETACHED;
                    sel_tab[i]   = 1'b0;
                    key_tab[i]   = '0;
                    stamp_tab[i] = '0;
                    pending_q.push_back(port_report(i, CAUSE_TIMEOUT));
                    produced++;
                end
            end
            if (produced > 0)
                pending_q[pending_q.size() - 1].last = 1'b1;
            return produced;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            end
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
                return;
            end
            want = pending_q.pop_front();
            checked++;
            compare_field("out_port", 64'(want.out_port), 64'(got.out_port));
            compare_field("cause", 64'(want.cause), 64'(got.cause));
            compare_field("port_state", 64'(want.port_state), 64'(got.port_state));
            compare_field("selected", 64'(want.selected), 64'(got.selected));
            compare_field("stored_peer_key", 64'(want.stored_peer_key),
                          64'(got.stored_peer_key));
            compare_field("stored_partner_priority", 64'(want.stored_partner_priority),
                          64'(got.stored_partner_priority));
            compare_field("member_mask", 64'(want.member_mask), 64'(got.member_mask));
            compare_field("member_total", 64'(want.member_total), 64'(got.member_total));
            compare_field("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for the LACP port selection engine.
module tb_top;
    import lse_pkg::*;
    import lse_scoreboard_pkg::*;

    // Cycles with no handshake on any channel before the run is declared hung;
    // covers the long receiver hold-off plus heavy random stalling.
    localparam int WATCHDOG_LIMIT  = 4000;
    // A tick walks up to 8 ports and emits up to 8 results; let it finish
    // even when it produced nothing we could wait for.
    localparam int QUIET_CYCLES    = 24;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 112;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req_data  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    bit          hold_off      = 1'b0;
    int          send_idle_pct = 14;
    int          recv_idle_pct = 51;
    logic [63:0] wall;
    int unsigned wall_step;
    int          ticks_sent;
    int          pdus_sent;
    int          reg_writes;
    int          idle_cycles;

    lse_scoreboard sb;

    lacp_port_selection_engine dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Check every result taken at this edge, then pick the stall for the next
    // cycle. A long hold-off overrides the random stall.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp_data);
        rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: count cycles in which no channel completes a handshake.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("FAIL lacp_port_selection_engine");
            $finish;
        end
    end

    function automatic req_t pdu_item(logic [2:0] port, logic [15:0] key, logic [7:0] st,
                                      logic [15:0] prio, logic [63:0] stamp, logic parsed);
        req_t r;
        r = '0;
        r.kind             = KIND_LACPDU;
        r.port             = port;
        r.parsed           = parsed;
        r.peer_key         = key;
        r.sender_state     = st;
        r.partner_priority = prio;
        r.now              = stamp;
        return r;
    endfunction

    function automatic req_t tick_item(logic [63:0] stamp);
        req_t r;
        r = '0;
        r.kind = KIND_TICK;
        r.now  = stamp;
        return r;
    endfunction

    // Mostly well-formed LACPDUs for the current key on member ports, a fair
    // share of ticks on a steadily advancing clock, and some noise: unparsed
    // frames, stray keys, high ports and wild time stamps.
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        int          n;
        n = sb.member_ports();
        pick = $urandom_range(99);
        r.kind             = KIND_LACPDU;
        r.port             = 3'($urandom_range(7));
        r.parsed           = 1'($urandom_range(1));
        r.peer_key         = 16'($urandom_range(65535));
        r.sender_state     = 8'($urandom_range(255));
        r.partner_priority = 16'($urandom_range(65535));
        r.now              = wall;
        if (pick < 25)
        begin
            r.kind = KIND_TICK;
        end
        else if (pick < 85 && n > 0)
        begin
            r.parsed                = 1'b1;
            r.port                  = 3'($urandom_range(n - 1));
            r.peer_key              = sb.local_key;
            r.sender_state[AGG_BIT] = 1'b1;
        end
        else
        begin
            if ($urandom_range(1))
                r.now = {$urandom, $urandom};
            if ($urandom_range(1))
                r.peer_key = sb.local_key;
        end
        wall += 64'($urandom_range(wall_step, 1));
        return r;
    endfunction

    // Offer one request, with a random gap first, and hold it until taken.
    task automatic send_request(input req_t r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do
            @(posedge clk);
        while (req_stall);
        if (r.kind == KIND_TICK)
            ticks_sent++;
        else
            pdus_sent++;
        void'(sb.note_request(r));
    endtask

    // Drop valid, wait for every expected result, then let a result-less
    // tick run out before touching registers or ending the run.
    task automatic settle_block();
        req_valid <= 1'b0;
        while (sb.pending_q.size() > 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Write all four registers back to back, then drop the write valid.
    task automatic program_regs(input logic [15:0] key, input logic mode,
                                input logic [63:0] age, input logic [3:0] ports);
        logic [CFG_IDX_W-1:0]  idx  [4];
        logic [CFG_DATA_W-1:0] vals [4];
        idx[0] = REG_LOCAL_KEY;    vals[0] = 64'(key);
        idx[1] = REG_ACTIVE_MODE;  vals[1] = 64'(mode);
        idx[2] = REG_TIMEOUT;      vals[2] = age;
        idx[3] = REG_PORTS_IN_USE; vals[3] = 64'(ports);
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.write_reg(idx[i], vals[i]);
            reg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        req_t       r;
        int         counted;
        bit         pressure_started;
        logic [63:0] age;
        sb = new();
        ticks_sent = 0;
        pdus_sent = 0;
        reg_writes = 0;
        idle_cycles = 0;
        pressure_started = 1'b0;
        wall = 64'd1;
        wall_step = 1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset values: key 1, active mode, long timeout,
        // all eight ports in use.
        send_request(pdu_item(3'd0, 16'd1, 8'h34, 16'h0000, 64'd100, 1'b0)); // unparsed: drop
        send_request(pdu_item(3'd0, 16'd1, 8'h34, 16'h0000, 64'd100, 1'b1)); // partner distributes
        send_request(pdu_item(3'd1, 16'd1, 8'h14, 16'hFFFF, 64'd200, 1'b1)); // active mode distributes
        send_request(pdu_item(3'd2, 16'd1, 8'h04, 16'h1234, 64'd300, 1'b1)); // attached only
        send_request(pdu_item(3'd3, 16'd0, 8'hFF, 16'h00FF, 64'd400, 1'b1)); // zero partner key
        send_request(pdu_item(3'd4, 16'd2, 8'hFF, 16'hFF00, 64'd500, 1'b1)); // key mismatch
        send_request(pdu_item(3'd5, 16'd1, 8'hFB, 16'h8001, 64'd600, 1'b1)); // no aggregation bit
        send_request(pdu_item(3'd6, 16'd1, 8'h34, 16'h0001, 64'd0, 1'b1));   // never-heard stamp
        send_request(pdu_item(3'd7, 16'd1, 8'h34, 16'hFFFF, '1, 1'b1));      // stamp at the top
        send_request(tick_item(64'd50));                    // stamps in the future: nothing
        send_request(tick_item(64'd1000000350));            // ports 0..2 age out
        send_request(tick_item(64'd1000000350));            // already cleared: nothing
        send_request(tick_item('1));                        // ports 3..5 age out
        settle_block();

        // Passive mode, all-ones key, longest timeout, three member ports.
        program_regs(16'hFFFF, 1'b0, '1, 4'd3);
        send_request(pdu_item(3'd5, 16'hFFFF, 8'h34, 16'h0005, 64'd10, 1'b1)); // non-member
        send_request(pdu_item(3'd1, 16'hFFFF, 8'h14, 16'h0011, 64'd10, 1'b1)); // collecting only
        send_request(pdu_item(3'd2, 16'hFFFF, 8'h34, 16'h0022, 64'd20, 1'b1)); // distributing
        send_request(pdu_item(3'd0, 16'hFFFF, 8'h24, 16'h0033, 64'd30, 1'b1)); // attached
        send_request(tick_item('1));                        // nothing reaches the timeout
        settle_block();

        // Zero key and zero timeout: a matching zero key still detaches, and
        // every heard member port goes on the next tick.
        program_regs(16'h0000, 1'b1, 64'd0, 4'd3);
        send_request(pdu_item(3'd0, 16'h0000, 8'hFF, 16'h0044, 64'd5, 1'b1));
        send_request(tick_item(64'd100));
        settle_block();

        // No member ports: everything is ignored.
        program_regs(16'h0001, 1'b1, TIMEOUT_RESET, 4'd0);
        send_request(pdu_item(3'd0, 16'h0001, 8'h34, 16'h0055, 64'd200, 1'b1));
        send_request(tick_item(64'd2000000000));

        // Random phases, each with its own register setting and idling mix.
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 14;
                    recv_idle_pct = 51;
                end
                1:
                begin
                    send_idle_pct = 51;
                    recv_idle_pct = 14;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            settle_block();
            age = 64'($urandom_range(3000, 200));
            program_regs(16'($urandom_range(65535, 1)), 1'($urandom_range(1)), age,
                         (ph == 0) ? 4'd8 : 4'($urandom_range(8, 1)));
            wall_step = 32'(age / 3);
            // Run one phase near the top of the time range.
            wall = (ph == 1) ? 64'hFFFF_FFFF_0000_0000 + 64'($urandom) : 64'($urandom) + 64'd1;
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                r = random_request();
                counted++;
                send_request(r);
                // Hold the receiver off for a long stretch while requests keep
                // coming, so the result register fills and the input stalls.
                if (ph == 0 && counted >= 40 && !pressure_started)
                begin
                    pressure_started = 1'b1;
                    fork
                        begin
                            hold_off <= 1'b1;
                            repeat (HOLD_CYCLES) @(posedge clk);
                            hold_off <= 1'b0;
                        end
                    join_none
                end
            end
        end
        settle_block();

        $display("Run covered %0d LACPDUs and %0d ticks over %0d register writes,",
                 pdus_sent, ticks_sent, reg_writes);
        $display("with %0d results checked field by field and %0d mismatches.",
                 sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("PASS lacp_port_selection_engine");
        else
            $display("FAIL lacp_port_selection_engine");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/lse_pkg.sv
hw/rtl/lse_ctrl.sv
hw/rtl/lse_dp.sv
hw/rtl/lacp_port_selection_engine.sv
tb/sv/lse_scoreboard_pkg.sv
tb/sv/tb_top.sv
